FILE: rtl/core/tritb_pkg.sv
`default_nettype none

package tritb_pkg;

  // Width of the sequencer step counter; it covers the longest loop
  // (32 square-root iterations, or OUT_FRAC_BITS + 1 divider steps).
  localparam int StepW = 6;
  localparam int OpW   = 4;

  // Datapath operation codes.
  localparam logic [OpW-1:0] OP_NONE   = 4'd0;
  localparam logic [OpW-1:0] OP_STORE  = 4'd1;
  localparam logic [OpW-1:0] OP_LATCH  = 4'd2;
  localparam logic [OpW-1:0] OP_EDGE   = 4'd3;
  localparam logic [OpW-1:0] OP_MUL    = 4'd4;
  localparam logic [OpW-1:0] OP_LOAD   = 4'd5;
  localparam logic [OpW-1:0] OP_SCALE  = 4'd6;
  localparam logic [OpW-1:0] OP_SQ     = 4'd7;
  localparam logic [OpW-1:0] OP_SQRT   = 4'd8;
  localparam logic [OpW-1:0] OP_DINIT  = 4'd9;
  localparam logic [OpW-1:0] OP_DSTEP  = 4'd10;
  localparam logic [OpW-1:0] OP_DSTORE = 4'd11;
  localparam logic [OpW-1:0] OP_FIN    = 4'd12;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic               degenerate;
  } result_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [StepW-1:0] step;
    logic             corner;
    logic             vsel;
    logic [1:0]       comp;
    logic             degen;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic scaled;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tritb_datapath.sv
`default_nettype none

module tritb_datapath #(
  parameter int CW = 32,
  parameter int F  = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tritb_pkg::cmd_t   cmd_i,
  input  wire tritb_pkg::vertex_t in_i,
  output tritb_pkg::status_t     stat_o,
  output tritb_pkg::result_t     out_o
);

  localparam int E    = CW + 1;
  localparam int TW   = 2 * E + 1;
  localparam int MW   = (E > 31) ? E : 31;
  localparam int PW   = 2 * MW;
  localparam int SW   = 62;
  localparam int BW   = 63;
  localparam int RW   = 31;
  localparam int NW   = F + 1;
  localparam int NUMW = 30 + NW;
  localparam int StW  = tritb_pkg::StepW;

  logic signed [CW-1:0] vp [3];
  logic signed [CW-1:0] vt [2];
  logic signed [CW-1:0] p0_q [3], p1_q [3], p2_q [3];
  logic signed [CW-1:0] t0_q [2], t1_q [2], t2_q [2];
  logic signed [E-1:0]  e1_q [3], e2_q [3];
  logic signed [E-1:0]  du1_q, dv1_q, du2_q, dv2_q;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_q;
  logic signed [TW-1:0] det_q, tc_q [3], bc_q [3];
  logic signed [TW-1:0] cur_term, nxt_term;
  logic [3:0]           term_j;
  logic [TW-1:0]        mag_q [3];
  logic                 neg_q [3];
  logic [TW-1:0]        orm;
  logic [SW-1:0]        sum_q;
  logic [BW-1:0]        root_q, bit_q, root_bit;
  logic [RW-1:0]        r;
  logic [RW-1:0]        rem_q;
  logic [NW-1:0]        low_q, quo_q;
  logic [NUMW-1:0]      numer;
  logic [RW:0]          trial;
  logic                 ge;
  logic [15:0]          qsat, qval;
  logic signed [15:0]   tres_q [3], bres_q [3];
  tritb_pkg::result_t   out_q;

  assign vp[0] = CW'(in_i.pos_x);
  assign vp[1] = CW'(in_i.pos_y);
  assign vp[2] = CW'(in_i.pos_z);
  assign vt[0] = CW'(in_i.tex_u);
  assign vt[1] = CW'(in_i.tex_v);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == tritb_pkg::OP_MUL) begin
      case (cmd_i.step[3:0])
        4'd0:  begin mul_a = MW'(du1_q); mul_b = MW'(dv2_q);   end
        4'd1:  begin mul_a = MW'(dv1_q); mul_b = MW'(du2_q);   end
        4'd2:  begin mul_a = MW'(dv2_q); mul_b = MW'(e1_q[0]); end
        4'd3:  begin mul_a = MW'(dv1_q); mul_b = MW'(e2_q[0]); end
        4'd4:  begin mul_a = MW'(dv2_q); mul_b = MW'(e1_q[1]); end
        4'd5:  begin mul_a = MW'(dv1_q); mul_b = MW'(e2_q[1]); end
        4'd6:  begin mul_a = MW'(dv2_q); mul_b = MW'(e1_q[2]); end
        4'd7:  begin mul_a = MW'(dv1_q); mul_b = MW'(e2_q[2]); end
        4'd8:  begin mul_a = MW'(du1_q); mul_b = MW'(e2_q[0]); end
        4'd9:  begin mul_a = MW'(du2_q); mul_b = MW'(e1_q[0]); end
        4'd10: begin mul_a = MW'(du1_q); mul_b = MW'(e2_q[1]); end
        4'd11: begin mul_a = MW'(du2_q); mul_b = MW'(e1_q[1]); end
        4'd12: begin mul_a = MW'(du1_q); mul_b = MW'(e2_q[2]); end
        4'd13: begin mul_a = MW'(du2_q); mul_b = MW'(e1_q[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.op == tritb_pkg::OP_SQ) begin
      case (cmd_i.step[1:0])
        2'd0:    mul_a = signed'(MW'(mag_q[0][29:0]));
        2'd1:    mul_a = signed'(MW'(mag_q[1][29:0]));
        2'd2:    mul_a = signed'(MW'(mag_q[2][29:0]));
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end
  end

  // Each cross term is the first product of its pair minus the second.
  assign term_j = cmd_i.step[3:0] - 4'd1;

  always_comb begin
    case (term_j[3:1])
      3'd0:    cur_term = det_q;
      3'd1:    cur_term = tc_q[0];
      3'd2:    cur_term = tc_q[1];
      3'd3:    cur_term = tc_q[2];
      3'd4:    cur_term = bc_q[0];
      3'd5:    cur_term = bc_q[1];
      default: cur_term = bc_q[2];
    endcase
    nxt_term = term_j[0] ? (cur_term - TW'(prod_q)) : TW'(prod_q);
  end

  assign orm      = mag_q[0] | mag_q[1] | mag_q[2];
  assign root_bit = root_q + bit_q;
  assign r        = root_q[RW-1:0];

  always_comb begin
    case (cmd_i.comp)
      2'd0:    numer = NUMW'(mag_q[0][29:0]);
      2'd1:    numer = NUMW'(mag_q[1][29:0]);
      default: numer = NUMW'(mag_q[2][29:0]);
    endcase
    numer = (numer << F) + NUMW'(r >> 1);
  end

  assign trial = {rem_q, low_q[NW-1]};
  assign ge    = (trial >= {1'b0, r});

  always_comb begin
    qsat = (32'(quo_q) > 32'd32767) ? 16'd32767 : 16'(quo_q);
    case (cmd_i.comp)
      2'd0:    qval = neg_q[0] ? (16'd0 - qsat) : qsat;
      2'd1:    qval = neg_q[1] ? (16'd0 - qsat) : qsat;
      default: qval = neg_q[2] ? (16'd0 - qsat) : qsat;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      tritb_pkg::OP_STORE: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd_i.corner) p1_q[k] <= vp[k];
          else              p0_q[k] <= vp[k];
        end
        for (int k = 0; k < 2; k++) begin
          if (cmd_i.corner) t1_q[k] <= vt[k];
          else              t0_q[k] <= vt[k];
        end
      end
      tritb_pkg::OP_LATCH: begin
        for (int k = 0; k < 3; k++) p2_q[k] <= vp[k];
        for (int k = 0; k < 2; k++) t2_q[k] <= vt[k];
      end
      tritb_pkg::OP_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= E'(p1_q[k]) - E'(p0_q[k]);
          e2_q[k] <= E'(p2_q[k]) - E'(p0_q[k]);
        end
        du1_q <= E'(t1_q[0]) - E'(t0_q[0]);
        dv1_q <= E'(t1_q[1]) - E'(t0_q[1]);
        du2_q <= E'(t2_q[0]) - E'(t0_q[0]);
        dv2_q <= E'(t2_q[1]) - E'(t0_q[1]);
      end
      tritb_pkg::OP_MUL: begin
        if (cmd_i.step != '0) begin
          case (term_j[3:1])
            3'd0:    det_q   <= nxt_term;
            3'd1:    tc_q[0] <= nxt_term;
            3'd2:    tc_q[1] <= nxt_term;
            3'd3:    tc_q[2] <= nxt_term;
            3'd4:    bc_q[0] <= nxt_term;
            3'd5:    bc_q[1] <= nxt_term;
            default: bc_q[2] <= nxt_term;
          endcase
        end
      end
      tritb_pkg::OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd_i.vsel) begin
            mag_q[k] <= bc_q[k][TW-1] ? TW'(-bc_q[k]) : bc_q[k];
            neg_q[k] <= bc_q[k][TW-1] ^ det_q[TW-1];
          end else begin
            mag_q[k] <= tc_q[k][TW-1] ? TW'(-tc_q[k]) : tc_q[k];
            neg_q[k] <= tc_q[k][TW-1] ^ det_q[TW-1];
          end
        end
      end
      tritb_pkg::OP_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          if (orm[TW-1:34] != '0)      mag_q[k] <= mag_q[k] >> 4;
          else if (orm[TW-1:30] != '0) mag_q[k] <= mag_q[k] >> 1;
          else if (orm == '0)          mag_q[k] <= mag_q[k];
          else if (orm[29:25] == '0)   mag_q[k] <= mag_q[k] << 4;
          else if (!orm[29])           mag_q[k] <= mag_q[k] << 1;
        end
      end
      tritb_pkg::OP_SQ: begin
        if (cmd_i.step == '0) begin
          root_q <= '0;
          bit_q  <= {1'b1, {(BW-1){1'b0}}};
        end else if (cmd_i.step == StW'(1)) begin
          sum_q <= SW'(prod_q);
        end else begin
          sum_q <= sum_q + SW'(prod_q);
        end
      end
      tritb_pkg::OP_SQRT: begin
        if (BW'(sum_q) >= root_bit) begin
          sum_q  <= SW'(BW'(sum_q) - root_bit);
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tritb_pkg::OP_DINIT: begin
        rem_q <= RW'(numer >> NW);
        low_q <= numer[NW-1:0];
        quo_q <= '0;
      end
      tritb_pkg::OP_DSTEP: begin
        rem_q <= ge ? RW'(trial - {1'b0, r}) : RW'(trial);
        low_q <= low_q << 1;
        quo_q <= {quo_q[NW-2:0], ge};
      end
      tritb_pkg::OP_DSTORE: begin
        if (cmd_i.vsel) bres_q[cmd_i.comp] <= signed'(qval);
        else            tres_q[cmd_i.comp] <= signed'(qval);
      end
      tritb_pkg::OP_FIN: begin
        out_q.tangent_x  <= cmd_i.degen ? '0 : tres_q[0];
        out_q.tangent_y  <= cmd_i.degen ? '0 : tres_q[1];
        out_q.tangent_z  <= cmd_i.degen ? '0 : tres_q[2];
        out_q.binormal_x <= cmd_i.degen ? '0 : bres_q[0];
        out_q.binormal_y <= cmd_i.degen ? '0 : bres_q[1];
        out_q.binormal_z <= cmd_i.degen ? '0 : bres_q[2];
        out_q.degenerate <= cmd_i.degen;
      end
      default: ;
    endcase
  end

  assign stat_o.det_zero = (det_q == '0);
  assign stat_o.vec_zero = (orm == '0);
  assign stat_o.scaled   = (orm == '0) || (orm[29] && (orm[TW-1:30] == '0));
  assign out_o = out_q;

  // Reset is not needed by any register here; keep the port referenced.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire

FILE: rtl/core/tritb_ctrl.sv
`default_nettype none

module tritb_ctrl #(
  parameter int F = 14
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire tritb_pkg::status_t stat_i,
  output tritb_pkg::cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EDGE   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_SCALE  = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_DINIT  = 4'd7;
  localparam logic [3:0] S_DSTEP  = 4'd8;
  localparam logic [3:0] S_DSTORE = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  localparam int SW = tritb_pkg::StepW;
  localparam logic [SW-1:0] MulLast  = SW'(14);
  localparam logic [SW-1:0] SqLast   = SW'(3);
  localparam logic [SW-1:0] SqrtLast = SW'(31);
  localparam logic [SW-1:0] DivLast  = SW'(F);

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [1:0]    corner_q, corner_d;
  logic          vec_q, vec_d;
  logic [1:0]    comp_q, comp_d;
  logic          degen_q, degen_d;
  logic          out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE) && ((corner_q != 2'd2) || !out_valid_q);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    corner_d    = corner_q;
    vec_d       = vec_q;
    comp_d      = comp_q;
    degen_d     = degen_q;
    out_valid_d = out_valid_q;
    cmd_o.op     = tritb_pkg::OP_NONE;
    cmd_o.step   = step_q;
    cmd_o.corner = corner_q[0];
    cmd_o.vsel   = vec_q;
    cmd_o.comp   = comp_q;
    cmd_o.degen  = degen_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (corner_q != 2'd2) begin
            cmd_o.op = tritb_pkg::OP_STORE;
            corner_d = corner_q + 2'd1;
          end else begin
            cmd_o.op = tritb_pkg::OP_LATCH;
            corner_d = 2'd0;
            degen_d  = 1'b0;
            state_d  = S_EDGE;
          end
        end
      end
      S_EDGE: begin
        cmd_o.op = tritb_pkg::OP_EDGE;
        step_d   = '0;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = tritb_pkg::OP_MUL;
        if (step_q == MulLast) begin
          vec_d = 1'b0;
          if (stat_i.det_zero) begin
            degen_d = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_LOAD;
          end
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      S_LOAD: begin
        cmd_o.op = tritb_pkg::OP_LOAD;
        state_d  = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = tritb_pkg::OP_SCALE;
        if (stat_i.scaled) begin
          if (stat_i.vec_zero) begin
            degen_d = 1'b1;
            state_d = S_FIN;
          end else begin
            step_d  = '0;
            state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.op = tritb_pkg::OP_SQ;
        if (step_q == SqLast) begin
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      S_SQRT: begin
        cmd_o.op = tritb_pkg::OP_SQRT;
        if (step_q == SqrtLast) begin
          comp_d  = 2'd0;
          state_d = S_DINIT;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      S_DINIT: begin
        cmd_o.op = tritb_pkg::OP_DINIT;
        step_d   = '0;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = tritb_pkg::OP_DSTEP;
        if (step_q == DivLast) state_d = S_DSTORE;
        else                   step_d  = step_q + SW'(1);
      end
      S_DSTORE: begin
        cmd_o.op = tritb_pkg::OP_DSTORE;
        if (comp_q == 2'd2) begin
          if (vec_q) begin
            state_d = S_FIN;
          end else begin
            vec_d   = 1'b1;
            state_d = S_LOAD;
          end
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DINIT;
        end
      end
      S_FIN: begin
        cmd_o.op    = tritb_pkg::OP_FIN;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      corner_q    <= 2'd0;
      vec_q       <= 1'b0;
      comp_q      <= 2'd0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      corner_q    <= corner_d;
      vec_q       <= vec_d;
      comp_q      <= comp_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/triangle_tangent_basis.sv
// Per-triangle tangent and binormal generator.
// The input channel (in_valid_i / in_ready_o / in_i) carries one vertex per
// transfer: position and texture coordinate in signed Q16.16. Every three
// vertices form a triangle. The first two corners are stored on arrival.
// The third corner starts the computation, and one result per triangle
// leaves on the output channel (out_valid_o / out_ready_i / out_o): unit
// tangent and binormal in signed fixed point with OUT_FRAC_BITS fraction
// bits, plus a degenerate flag that zeroes both vectors.
// Per vector, the computation runs a normalizing shift and the 32-step
// bit-serial square root; the restoring divider, one quotient bit per
// cycle, runs once per vector component. A degenerate triangle finishes
// early. Reset returns the corner counter to the first corner and drops
// any pending result. When the receiver stalls, the result waits in the
// output register and the block still takes the first two corners of
// the next triangle; the third waits for the transfer.
`default_nettype none

module triangle_tangent_basis #(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tritb_pkg::vertex_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tritb_pkg::result_t       out_o
);

  // Command and status between the sequencer and the arithmetic datapath.
  tritb_pkg::cmd_t    cmd;
  tritb_pkg::status_t stat;

  tritb_ctrl #(
    .F(OUT_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the corners, one shared multiplier, the scaling
  // shifter, the square root and the divider.
  tritb_datapath #(
    .CW(COORD_WIDTH),
    .F (OUT_FRAC_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
